// ===== hdl/ssm_pkg.sv =====
// Shared types and defaults for the sorted stream merge block.
// No dependencies; used by sorted_stream_merge_top.
package ssm_pkg;

   localparam int FIFO_DEPTH_DEF  = 32;
   localparam int VALUE_WIDTH_DEF = 32;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_DATA     = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OVF,
      ST_READ,
      ST_PICK,
      ST_EMPTY
   } state_type;

endpackage

// ===== hdl/ssm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sorted_stream_merge_top.sv =====
// Top level of the sorted stream merge block: two element FIFOs in RAM and
// the merge sequencer. Depends on ssm_pkg and ssm_ram.
//
// Two-way merge of two ascending sequences of signed words. Each input item
// names a sequence (req_list_select), may carry one element (req_has_value,
// req_value) and may end that sequence (req_end_of_list). Elements wait in
// one RAM-based FIFO per sequence, FIFO_DEPTH entries each. While both FIFOs
// hold a head the smaller head goes out (the first sequence wins a tie);
// once one sequence has ended and drained, the other one flushes. An element
// pushed into a full FIFO is dropped and reported with an overflow item; an
// item for a sequence that has already ended is ignored. The last result of
// each input item carries rsp_last_of_run, and the last result of the whole
// merge carries rsp_last_of_merge, after which the block is back in its
// reset state. When the item that finishes the merge would give no other
// result, one empty-done status item is sent instead.
// Sequence: one input item is taken at a time. An accepted item leaves the
// idle state for an overflow step if its element is dropped, then for a head
// read step; each element is then emitted in a pick step, with another head
// read step between two elements (the head RAMs have registered read data and
// are read anew after every pop), or an empty-done item is emitted in its own
// step. The overflow, pick and empty-done steps wait while the output is
// stalled. The output register lets the next item in while the last result
// still waits to be taken. No clearing pass is needed at reset.
module sorted_stream_merge_top #(
   parameter int FIFO_DEPTH  = ssm_pkg::FIFO_DEPTH_DEF,
   parameter int VALUE_WIDTH = ssm_pkg::VALUE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_list_select,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  logic                          req_has_value,
   input  logic                          req_end_of_list,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VALUE_WIDTH-1:0] rsp_out_value,
   output logic                          rsp_from_list,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_last_of_run,
   output logic                          rsp_last_of_merge
);

   localparam int AW = $clog2(FIFO_DEPTH);      // FIFO address width
   localparam int CW = $clog2(FIFO_DEPTH + 1);  // fill count width
   localparam int SW = CW + 1;                  // head + count sum width

   // ---------------------------------------------------------------
   // State
   // ---------------------------------------------------------------
   ssm_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [AW-1:0]      head_a_ff, head_a_in, head_b_ff, head_b_in;
   logic               end_a_ff, end_a_in, end_b_ff, end_b_in;
   logic               ovf_sel_ff, ovf_sel_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                   rsp_from_ff, rsp_from_in;
   ssm_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic                   rsp_lrun_ff, rsp_lrun_in;
   logic                   rsp_lmerge_ff, rsp_lmerge_in;

   // RAM ports
   logic                   wr_en_a, wr_en_b;
   logic [AW-1:0]          wr_addr;
   logic [VALUE_WIDTH-1:0] rd_data_a, rd_data_b;

   // scratch for the sequencer
   logic                   out_free;
   logic                   req_accept;
   logic [CW-1:0]          sel_cnt;
   logic [AW-1:0]          sel_head;
   logic                   sel_end;
   logic [SW-1:0]          wr_sum;
   logic                   pick_b;
   logic [CW-1:0]          post_a, post_b;
   logic                   more, fin;

   // A pop is due when both heads exist, or one exists and the other
   // sequence is closed.
   function automatic logic pop_due(input logic [CW-1:0] ca, input logic [CW-1:0] cb,
                                    input logic ea, input logic eb);
      pop_due = ((ca != '0) && (cb != '0)) || ((ca != '0) && eb) || ((cb != '0) && ea);
   endfunction

   // ---------------------------------------------------------------
   // FIFO storage
   // ---------------------------------------------------------------
   ssm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(FIFO_DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en_a),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (head_a_ff),
      .rd_data (rd_data_a)
   );

   ssm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(FIFO_DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en_b),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (head_b_ff),
      .rd_data (rd_data_b)
   );

   // Tail address = (head + count) mod depth; the sum stays below twice
   // the depth, so one compare and subtract folds it.
   assign sel_cnt  = req_list_select ? cnt_b_ff  : cnt_a_ff;
   assign sel_head = req_list_select ? head_b_ff : head_a_ff;
   assign sel_end  = req_list_select ? end_b_ff  : end_a_ff;
   assign wr_sum   = SW'(sel_head) + SW'(sel_cnt);
   assign wr_addr  = (wr_sum >= SW'(FIFO_DEPTH)) ? AW'(wr_sum - SW'(FIFO_DEPTH))
                                                : AW'(wr_sum);

   assign req_stall  = (state_ff != ssm_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Head choice; tie goes to the first sequence.
   assign pick_b = ((cnt_a_ff != '0) && (cnt_b_ff != '0))
                   ? ($signed(rd_data_b) < $signed(rd_data_a))
                   : (cnt_a_ff == '0);
   assign post_a = pick_b ? cnt_a_ff : cnt_a_ff - CW'(1);
   assign post_b = pick_b ? cnt_b_ff - CW'(1) : cnt_b_ff;
   assign more   = pop_due(post_a, post_b, end_a_ff, end_b_ff);
   assign fin    = end_a_ff && end_b_ff && (post_a == '0) && (post_b == '0);

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      head_a_in     = head_a_ff;
      head_b_in     = head_b_ff;
      end_a_in      = end_a_ff;
      end_b_in      = end_b_ff;
      ovf_sel_in    = ovf_sel_ff;
      wr_en_a       = 1'b0;
      wr_en_b       = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_from_in   = rsp_from_ff;
      rsp_status_in = rsp_status_ff;
      rsp_lrun_in   = rsp_lrun_ff;
      rsp_lmerge_in = rsp_lmerge_ff;

      case (state_ff)
         ssm_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in   = ssm_pkg::ST_READ;
               ovf_sel_in = req_list_select;
               if (!sel_end) begin
                  if (req_has_value) begin
                     if (sel_cnt == CW'(FIFO_DEPTH)) begin
                        state_in = ssm_pkg::ST_OVF;
                     end else if (req_list_select) begin
                        wr_en_b  = 1'b1;
                        cnt_b_in = cnt_b_ff + CW'(1);
                     end else begin
                        wr_en_a  = 1'b1;
                        cnt_a_in = cnt_a_ff + CW'(1);
                     end
                  end
                  if (req_end_of_list) begin
                     if (req_list_select) begin
                        end_b_in = 1'b1;
                     end else begin
                        end_a_in = 1'b1;
                     end
                  end
               end
            end
         end

         // Dropped element; the full FIFO keeps the merge open.
         ssm_pkg::ST_OVF: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_from_in   = ovf_sel_ff;
               rsp_status_in = ssm_pkg::STATUS_OVERFLOW;
               rsp_lrun_in   = !pop_due(cnt_a_ff, cnt_b_ff, end_a_ff, end_b_ff);
               rsp_lmerge_in = 1'b0;
               state_in      = ssm_pkg::ST_READ;
            end
         end

         // Head read data lands at the end of this cycle.
         ssm_pkg::ST_READ: begin
            if (pop_due(cnt_a_ff, cnt_b_ff, end_a_ff, end_b_ff)) begin
               state_in = ssm_pkg::ST_PICK;
            end else if (end_a_ff && end_b_ff && (cnt_a_ff == '0) && (cnt_b_ff == '0)) begin
               state_in = ssm_pkg::ST_EMPTY;
            end else begin
               state_in = ssm_pkg::ST_IDLE;
            end
         end

         ssm_pkg::ST_PICK: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = pick_b ? rd_data_b : rd_data_a;
               rsp_from_in   = pick_b;
               rsp_status_in = ssm_pkg::STATUS_DATA;
               rsp_lrun_in   = !more;
               rsp_lmerge_in = fin;
               cnt_a_in      = post_a;
               cnt_b_in      = post_b;
               if (pick_b) begin
                  head_b_in = (head_b_ff == AW'(FIFO_DEPTH - 1)) ? '0 : head_b_ff + AW'(1);
               end else begin
                  head_a_in = (head_a_ff == AW'(FIFO_DEPTH - 1)) ? '0 : head_a_ff + AW'(1);
               end
               if (fin) begin
                  head_a_in = '0;
                  head_b_in = '0;
                  end_a_in  = 1'b0;
                  end_b_in  = 1'b0;
               end
               state_in = more ? ssm_pkg::ST_READ : ssm_pkg::ST_IDLE;
            end
         end

         // Merge closed with nothing to send: one empty-done item.
         ssm_pkg::ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_from_in   = 1'b0;
               rsp_status_in = ssm_pkg::STATUS_EMPTY;
               rsp_lrun_in   = 1'b1;
               rsp_lmerge_in = 1'b1;
               cnt_a_in      = '0;
               cnt_b_in      = '0;
               head_a_in     = '0;
               head_b_in     = '0;
               end_a_in      = 1'b0;
               end_b_in      = 1'b0;
               state_in      = ssm_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ssm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssm_pkg::ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         head_a_ff    <= '0;
         head_b_ff    <= '0;
         end_a_ff     <= 1'b0;
         end_b_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         head_a_ff    <= head_a_in;
         head_b_ff    <= head_b_in;
         end_a_ff     <= end_a_in;
         end_b_ff     <= end_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ovf_sel_ff    <= ovf_sel_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_from_ff   <= rsp_from_in;
      rsp_status_ff <= rsp_status_in;
      rsp_lrun_ff   <= rsp_lrun_in;
      rsp_lmerge_ff <= rsp_lmerge_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_value     = $signed(rsp_value_ff);
   assign rsp_from_list     = rsp_from_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last_of_run   = rsp_lrun_ff;
   assign rsp_last_of_merge = rsp_lmerge_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // Fill counts never pass the depth.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (cnt_a_ff <= CW'(FIFO_DEPTH)) && (cnt_b_ff <= CW'(FIFO_DEPTH)))
      else $error("FIFO fill count beyond depth");

   // Between items the merge has drained everything it could.
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssm_pkg::ST_IDLE) |-> !pop_due(cnt_a_ff, cnt_b_ff, end_a_ff, end_b_ff))
      else $error("idle with a pop still due");

   // End of merge is always also end of the item's run.
   a_merge_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_merge) |-> rsp_last_of_run)
      else $error("last_of_merge without last_of_run");

   // A finished merge leaves the block in its reset state.
   a_merge_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_merge && !$stable(rsp_valid_ff && rsp_lmerge_ff && rsp_valid))
      |-> (cnt_a_ff == '0) && (cnt_b_ff == '0) && !end_a_ff && !end_b_ff)
      else $error("merge finished but state not cleared");

   // An overflow is only reported for a full FIFO.
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssm_pkg::ST_OVF) |->
      ((ovf_sel_ff ? cnt_b_ff : cnt_a_ff) == CW'(FIFO_DEPTH)))
      else $error("overflow without a full FIFO");

endmodule
